[hdl/stq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Command and result codes, control state encoding and the control word
// that the top level hands to every cell of the sorted deadline chain.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam logic [2:0] CMD_ALLOCATE = 3'd0;
   localparam logic [2:0] CMD_FREE     = 3'd1;
   localparam logic [2:0] CMD_BIND     = 3'd2;
   localparam logic [2:0] CMD_ARM      = 3'd3;
   localparam logic [2:0] CMD_TICK     = 3'd4;

   localparam logic [1:0] KIND_GRANTED   = 2'd0;
   localparam logic [1:0] KIND_NONE_FREE = 2'd1;
   localparam logic [1:0] KIND_EXPIRED   = 2'd2;

   // At most this many timers expire on one tick.
   localparam int unsigned RESULT_LIMIT = 32;
   localparam int unsigned COUNT_W      = 6;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ARM  = 3'b010,
      ST_TICK = 3'b100
   } stq_state_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } stq_ctrl_type;

endpackage
`default_nettype wire

[hdl/sorted_timer_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted timer queue
// A pool of software timers; running timers are held sorted by deadline in
// a chain of cells, with destinations and event words in a slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   A command item is taken on a rising edge with start high and busy low.
//   Allocate answers with one result in the next cycle (granted slot or no
//   free slot). Free and bind give no result. Arm first adds the deadline
//   to the tick count, then the chain of cells shifts it into place.
//   Tick first advances the tick count, then pops one expired timer per
//   cycle from the head of the chain, at most 32 per tick; each result is
//   registered and appears in the cycle after its pop, the last one marked
//   by rsp_last.
//   Results appear on rsp_strobe for one cycle and cannot be held off.
//   Reset empties the chain, frees all slots and clears the tick count;
//   destinations and event words stay undefined until bound.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
   parameter int unsigned TIMER_SLOTS  = 32,
   parameter int unsigned DESTINATIONS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [2:0]  req_command,
   input  wire  [4:0]  req_timer_index,
   input  wire  [3:0]  req_destination,
   input  wire  [31:0] req_event_value,
   input  wire  [31:0] req_timeout,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_kind,
   output logic [4:0]  rsp_slot,
   output logic [3:0]  rsp_target,
   output logic [31:0] rsp_word,
   output logic        rsp_last
);

   localparam int unsigned SLOT_W = $clog2(TIMER_SLOTS);

   stq_pkg::stq_state_type state_ff, state_in;
   logic [TIMER_SLOTS-1:0] alloc_ff, alloc_in;
   logic [TIMER_SLOTS-1:0] run_ff, run_in;
   logic [31:0]            tick_ff, tick_in;
   logic [31:0]            new_dl_ff, new_dl_in;
   logic [SLOT_W-1:0]      new_slot_ff, new_slot_in;
   logic [stq_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]             rsp_kind_ff, rsp_kind_in;
   logic [4:0]             rsp_slot_ff, rsp_slot_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [3:0]             rsp_target_ff;
   logic [31:0]            rsp_word_ff;

   logic [3:0]             target_mem [TIMER_SLOTS];
   logic [31:0]            word_mem   [TIMER_SLOTS];

   stq_pkg::stq_ctrl_type  ctrl;
   logic                   bind_we;
   logic                   clear_data;
   logic [SLOT_W-1:0]      idx;
   logic                   in_range;
   logic                   dest_ok;
   logic                   free_found;
   logic [SLOT_W-1:0]      free_slot;
   logic                   head_due;
   logic                   next_due;

   // Chain wiring: cell i sits at index i+1; index 0 and TIMER_SLOTS+1 are
   // the empty boundaries.
   logic                   v_w    [TIMER_SLOTS+2];
   logic [SLOT_W-1:0]      slot_w [TIMER_SLOTS+2];
   logic [31:0]            dl_w   [TIMER_SLOTS+2];
   logic                   ge_w   [TIMER_SLOTS+1];

   assign v_w[0]                = 1'b0;
   assign slot_w[0]             = '0;
   assign dl_w[0]               = '0;
   assign ge_w[0]               = 1'b0;
   assign v_w[TIMER_SLOTS+1]    = 1'b0;
   assign slot_w[TIMER_SLOTS+1] = '0;
   assign dl_w[TIMER_SLOTS+1]   = '0;

   for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
      stq_cell #(
         .SLOT_W(SLOT_W)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .new_slot       (new_slot_ff),
         .new_deadline   (new_dl_ff),
         .left_valid     (v_w[i]),
         .left_slot      (slot_w[i]),
         .left_deadline  (dl_w[i]),
         .left_ge        (ge_w[i]),
         .right_valid    (v_w[i+2]),
         .right_slot     (slot_w[i+2]),
         .right_deadline (dl_w[i+2]),
         .cell_valid     (v_w[i+1]),
         .cell_slot      (slot_w[i+1]),
         .cell_deadline  (dl_w[i+1]),
         .cell_ge        (ge_w[i+1])
      );
   end

   assign busy       = (state_ff != stq_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_target = rsp_target_ff;
   assign rsp_word   = rsp_word_ff;
   assign rsp_last   = rsp_last_ff;

   assign idx      = SLOT_W'(req_timer_index);
   assign in_range = (32'(req_timer_index) < 32'(TIMER_SLOTS));
   assign dest_ok  = (32'(req_destination) < 32'(DESTINATIONS));

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!alloc_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   assign head_due = v_w[1] && (dl_w[1] <= tick_ff)
                     && (count_ff < stq_pkg::COUNT_W'(stq_pkg::RESULT_LIMIT));
   assign next_due = v_w[2] && (dl_w[2] <= tick_ff)
                     && ((count_ff + 1'b1) < stq_pkg::COUNT_W'(stq_pkg::RESULT_LIMIT));

   always_comb begin
      state_in      = state_ff;
      alloc_in      = alloc_ff;
      run_in        = run_ff;
      tick_in       = tick_ff;
      new_dl_in     = new_dl_ff;
      new_slot_in   = new_slot_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      ctrl          = '0;
      bind_we       = 1'b0;
      clear_data    = 1'b0;
      case (state_ff)
         stq_pkg::ST_IDLE: begin
            if (start) begin
               case (req_command)
                  stq_pkg::CMD_ALLOCATE: begin
                     rsp_strobe_in = 1'b1;
                     rsp_last_in   = 1'b1;
                     clear_data    = 1'b1;
                     if (free_found) begin
                        alloc_in[free_slot] = 1'b1;
                        rsp_kind_in         = stq_pkg::KIND_GRANTED;
                        rsp_slot_in         = 5'(free_slot);
                     end else begin
                        rsp_kind_in = stq_pkg::KIND_NONE_FREE;
                        rsp_slot_in = '0;
                     end
                  end
                  stq_pkg::CMD_FREE: begin
                     if (in_range && !run_ff[idx]) begin
                        alloc_in[idx] = 1'b0;
                     end
                  end
                  stq_pkg::CMD_BIND: begin
                     bind_we = in_range && dest_ok;
                  end
                  stq_pkg::CMD_ARM: begin
                     if (in_range && alloc_ff[idx] && !run_ff[idx]) begin
                        new_dl_in   = req_timeout + tick_ff;
                        new_slot_in = idx;
                        state_in    = stq_pkg::ST_ARM;
                     end
                  end
                  stq_pkg::CMD_TICK: begin
                     tick_in  = tick_ff + 32'd1;
                     count_in = '0;
                     state_in = stq_pkg::ST_TICK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         stq_pkg::ST_ARM: begin
            ctrl.insert         = 1'b1;
            run_in[new_slot_ff] = 1'b1;
            state_in            = stq_pkg::ST_IDLE;
         end
         stq_pkg::ST_TICK: begin
            if (head_due) begin
               ctrl.pop          = 1'b1;
               run_in[slot_w[1]] = 1'b0;
               rsp_strobe_in     = 1'b1;
               rsp_kind_in       = stq_pkg::KIND_EXPIRED;
               rsp_slot_in       = 5'(slot_w[1]);
               rsp_last_in       = !next_due;
               count_in          = count_ff + 1'b1;
               if (!next_due) begin
                  state_in = stq_pkg::ST_IDLE;
               end
            end else begin
               state_in = stq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stq_pkg::ST_IDLE;
         alloc_ff      <= '0;
         run_ff        <= '0;
         tick_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         alloc_ff      <= alloc_in;
         run_ff        <= run_in;
         tick_ff       <= tick_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      new_dl_ff   <= new_dl_in;
      new_slot_ff <= new_slot_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Slot memory; its read port loads the result registers directly.
   always_ff @(posedge clock) begin
      if (bind_we) begin
         target_mem[idx] <= req_destination;
         word_mem[idx]   <= req_event_value;
      end
      if (ctrl.pop) begin
         rsp_target_ff <= target_mem[slot_w[1]];
         rsp_word_ff   <= word_mem[slot_w[1]];
      end else if (clear_data) begin
         rsp_target_ff <= '0;
         rsp_word_ff   <= '0;
      end
   end

   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> v_w[1])
      else $error("pop issued on an empty chain");

   a_chain_sorted: assert property (@(posedge clock) disable iff (reset)
      (v_w[1] && v_w[2]) |-> (dl_w[1] <= dl_w[2]))
      else $error("head of the chain is later than its successor");

   a_insert_fills_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stq_pkg::ST_ARM) |=> v_w[1])
      else $error("chain head empty after an insert");

   a_expiry_from_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_kind == stq_pkg::KIND_EXPIRED))
         |-> $past(state_ff == stq_pkg::ST_TICK))
      else $error("expiry item outside a tick");

endmodule
`default_nettype wire

[hdl/stq_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted timer queue cell
// One place of the sorted chain: holds a running timer's slot and deadline.
// On insert it keeps its entry, takes the new one or takes its left
// neighbor's; on pop it takes its right neighbor's.
// ----------------------------------------------------------------------------
module stq_cell #(
   parameter int unsigned SLOT_W = 5
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire stq_pkg::stq_ctrl_type ctrl,
   input  wire  [SLOT_W-1:0]       new_slot,
   input  wire  [31:0]             new_deadline,
   input  wire                     left_valid,
   input  wire  [SLOT_W-1:0]       left_slot,
   input  wire  [31:0]             left_deadline,
   input  wire                     left_ge,
   input  wire                     right_valid,
   input  wire  [SLOT_W-1:0]       right_slot,
   input  wire  [31:0]             right_deadline,
   output logic                    cell_valid,
   output logic [SLOT_W-1:0]       cell_slot,
   output logic [31:0]             cell_deadline,
   output logic                    cell_ge
);

   logic              valid_ff, valid_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [31:0]       deadline_ff, deadline_in;

   // The new timer belongs at or before this place; an empty place always qualifies.
   assign cell_ge       = !valid_ff || (new_deadline <= deadline_ff);
   assign cell_valid    = valid_ff;
   assign cell_slot     = slot_ff;
   assign cell_deadline = deadline_ff;

   always_comb begin
      valid_in    = valid_ff;
      slot_in     = slot_ff;
      deadline_in = deadline_ff;
      if (ctrl.pop) begin
         valid_in    = right_valid;
         slot_in     = right_slot;
         deadline_in = right_deadline;
      end else if (ctrl.insert && cell_ge) begin
         if (left_ge) begin
            valid_in    = left_valid;
            slot_in     = left_slot;
            deadline_in = left_deadline;
         end else begin
            valid_in    = 1'b1;
            slot_in     = new_slot;
            deadline_in = new_deadline;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      slot_ff     <= slot_in;
      deadline_ff <= deadline_in;
   end

endmodule
`default_nettype wire

[test/sorted_timer_queue_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted timer queue testbench
// Drives allocate, free, bind, arm and tick commands into the timer pool and
// checks every slot grant and timer expiry against a predictor that keeps
// its own copy of the slots and of the deadline-ordered list of running
// timers. Directed cases come first, then a full pool, then random traffic
// under several sender idling phases.
// ----------------------------------------------------------------------------
module sorted_timer_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS         = 32;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 200000;

   localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  slot;
      logic [3:0]  target;
      logic [31:0] word;
      logic        last;
   } timer_event_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        start           = 1'b0;
   logic [2:0]  req_command     = '0;
   logic [4:0]  req_timer_index = '0;
   logic [3:0]  req_destination = '0;
   logic [31:0] req_event_value = '0;
   logic [31:0] req_timeout     = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [1:0]  rsp_kind;
   logic [4:0]  rsp_slot;
   logic [3:0]  rsp_target;
   logic [31:0] rsp_word;
   logic        rsp_last;

   // Predicted state of the pool.
   logic        slot_taken   [SLOTS];
   logic        slot_running [SLOTS];
   logic        slot_bound   [SLOTS];
   logic [31:0] slot_deadline[SLOTS];
   logic [3:0]  slot_target  [SLOTS];
   logic [31:0] slot_word    [SLOTS];
   logic [4:0]  deadline_order[$];
   logic [31:0] tick_now = '0;

   timer_event_type pending_events[$];
   int              failures    = 0;
   int              idle_pct    = 0;
   int              cycle_count = 0;

   sorted_timer_queue i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_timer_index(req_timer_index),
      .req_destination(req_destination),
      .req_event_value(req_event_value),
      .req_timeout    (req_timeout),
      .rsp_strobe     (rsp_strobe),
      .rsp_kind       (rsp_kind),
      .rsp_slot       (rsp_slot),
      .rsp_target     (rsp_target),
      .rsp_word       (rsp_word),
      .rsp_last       (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL sorted_timer_queue");
         $finish;
      end
   end

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         slot_taken[s]    = 1'b0;
         slot_running[s]  = 1'b0;
         slot_bound[s]    = 1'b0;
         slot_deadline[s] = '0;
         slot_target[s]   = '0;
         slot_word[s]     = '0;
      end
   end

   // Works out the grants and expiries that one accepted command causes.
   task automatic predict_timer_results(input logic [2:0] cmd, input logic [4:0] idx,
                                        input logic [3:0] dest, input logic [31:0] value,
                                        input logic [31:0] tmo);
      timer_event_type ev;
      timer_event_type batch[$];
      logic [31:0]     due;
      int              pos;
      int              s;
      ev = '0;
      case (cmd)
         stq_pkg::CMD_ALLOCATE: begin
            ev.kind = stq_pkg::KIND_NONE_FREE;
            ev.last = 1'b1;
            for (s = 0; s < SLOTS; s++) begin
               if (!slot_taken[s]) begin
                  slot_taken[s] = 1'b1;
                  ev.kind = stq_pkg::KIND_GRANTED;
                  ev.slot = 5'(s);
                  break;
               end
            end
            pending_events.push_back(ev);
         end
         stq_pkg::CMD_FREE: begin
            if (!slot_running[idx]) slot_taken[idx] = 1'b0;
         end
         stq_pkg::CMD_BIND: begin
            slot_target[idx] = dest;
            slot_word[idx]   = value;
            slot_bound[idx]  = 1'b1;
         end
         stq_pkg::CMD_ARM: begin
            if (slot_taken[idx] && !slot_running[idx]) begin
               due = tmo + tick_now;
               slot_deadline[idx] = due;
               slot_running[idx]  = 1'b1;
               // A new timer goes ahead of queued ones with an equal deadline.
               pos = 0;
               while (pos < deadline_order.size() &&
                      due > slot_deadline[deadline_order[pos]])
                  pos++;
               deadline_order.insert(pos, idx);
            end
         end
         stq_pkg::CMD_TICK: begin
            tick_now = tick_now + 32'd1;
            while (deadline_order.size() > 0 &&
                   batch.size() < int'(stq_pkg::RESULT_LIMIT) &&
                   slot_deadline[deadline_order[0]] <= tick_now) begin
               s = int'(deadline_order.pop_front());
               slot_running[s] = 1'b0;
               ev.kind   = stq_pkg::KIND_EXPIRED;
               ev.slot   = 5'(s);
               ev.target = slot_target[s];
               ev.word   = slot_word[s];
               ev.last   = 1'b0;
               batch.push_back(ev);
            end
            if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            foreach (batch[k]) pending_events.push_back(batch[k]);
         end
         default: ;
      endcase
   endtask

   function automatic int field_mismatch(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: rsp_%s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      timer_event_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_events.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual kind %0d slot %0d",
                     $time, rsp_kind, rsp_slot);
            failures++;
         end else begin
            want = pending_events.pop_front();
            failures += field_mismatch("kind", 32'(want.kind), 32'(rsp_kind));
            failures += field_mismatch("slot", 32'(want.slot), 32'(rsp_slot));
            failures += field_mismatch("target", 32'(want.target), 32'(rsp_target));
            failures += field_mismatch("word", want.word, rsp_word);
            failures += field_mismatch("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // Presents one command item, waits for it to be taken, then maybe idles.
   task automatic send_command(input logic [2:0] cmd, input logic [4:0] idx,
                               input logic [3:0] dest, input logic [31:0] value,
                               input logic [31:0] tmo);
      int gap;
      req_command     <= cmd;
      req_timer_index <= idx;
      req_destination <= dest;
      req_event_value <= value;
      req_timeout     <= tmo;
      start           <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_timer_results(cmd, idx, dest, value, tmo);
      gap = 0;
      if ($urandom_range(0, 99) < idle_pct) gap = int'($urandom_range(1, 8));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [4:0] pick_taken_slot(input logic [4:0] fallback);
      logic [4:0] candidates[$];
      for (int s = 0; s < SLOTS; s++)
         if (slot_taken[s]) candidates.push_back(5'(s));
      if (candidates.size() == 0) return fallback;
      return candidates[$urandom_range(0, candidates.size() - 1)];
   endfunction

   function automatic logic [31:0] pick_timeout();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 80) return 32'($urandom_range(0, 5));
      // Deadlines that wrap past zero land at or just above zero and expire soon.
      if (r < 97) return 32'd0 - tick_now + 32'($urandom_range(0, 6));
      return $urandom;
   endfunction

   task automatic test_basic_commands();
      send_command(stq_pkg::CMD_ALLOCATE, 5'd0, 4'd0, 32'd0, 32'd0);
      send_command(stq_pkg::CMD_ALLOCATE, 5'd31, 4'd15, 32'hffff_ffff, 32'hffff_ffff);
      send_command(stq_pkg::CMD_BIND, 5'd0, 4'd15, 32'hffff_ffff, 32'd0);
      send_command(stq_pkg::CMD_BIND, 5'd1, 4'd0, 32'd0, 32'hffff_ffff);
      // Binding is allowed on a slot that was never allocated; arming is not.
      send_command(stq_pkg::CMD_BIND, 5'd31, 4'd10, 32'h5a5a_a5a5, 32'd0);
      send_command(stq_pkg::CMD_ARM, 5'd31, 4'd0, 32'd0, 32'd1);
      for (logic [3:0] c = 4'(CMD_RESERVED_FIRST); c <= 4'(CMD_RESERVED_LAST); c++)
         send_command(3'(c), 5'($urandom), 4'($urandom), $urandom, $urandom);
   endtask

   task automatic test_equal_deadlines();
      send_command(stq_pkg::CMD_ARM, 5'd0, 4'd0, 32'd0, 32'd2);
      send_command(stq_pkg::CMD_ARM, 5'd1, 4'd0, 32'd0, 32'd2);
      // Re-arming or freeing a running timer has no effect.
      send_command(stq_pkg::CMD_ARM, 5'd0, 4'd0, 32'd0, 32'd0);
      send_command(stq_pkg::CMD_FREE, 5'd0, 4'd0, 32'd0, 32'd0);
      send_command(stq_pkg::CMD_TICK, 5'd0, 4'd0, 32'd0, 32'd0);
      send_command(stq_pkg::CMD_TICK, 5'd0, 4'd0, 32'd0, 32'd0);
      // Expired slots stay allocated, so the next grant skips them.
      send_command(stq_pkg::CMD_ALLOCATE, 5'd0, 4'd0, 32'd0, 32'd0);
      send_command(stq_pkg::CMD_FREE, 5'd2, 4'd0, 32'd0, 32'd0);
      send_command(stq_pkg::CMD_ARM, 5'd2, 4'd0, 32'd0, 32'd0);
   endtask

   task automatic test_deadline_wrap();
      send_command(stq_pkg::CMD_ARM, 5'd0, 4'd0, 32'd0, 32'hffff_ffff);
      send_command(stq_pkg::CMD_ARM, 5'd1, 4'd0, 32'd0, 32'd0);
      send_command(stq_pkg::CMD_TICK, 5'd0, 4'd0, 32'd0, 32'd0);
   endtask

   // Every slot expires on one tick, and one allocation finds the pool full.
   task automatic test_full_pool();
      int k;
      int open_slots;
      int base;
      open_slots = 0;
      for (k = 0; k < SLOTS; k++)
         if (!slot_taken[k]) open_slots++;
      for (k = 0; k <= open_slots; k++)
         send_command(stq_pkg::CMD_ALLOCATE, 5'($urandom), 4'($urandom), $urandom,
                      $urandom);
      for (k = 0; k < SLOTS; k++)
         send_command(stq_pkg::CMD_BIND, 5'(k), 4'($urandom), $urandom, $urandom);
      base = int'($urandom_range(0, SLOTS - 1));
      for (k = 0; k < SLOTS; k++)
         send_command(stq_pkg::CMD_ARM, 5'((base + k) % SLOTS), 4'($urandom), $urandom,
                      32'($urandom_range(0, 1)));
      send_command(stq_pkg::CMD_TICK, 5'($urandom), 4'($urandom), $urandom, $urandom);
      for (k = 0; k < SLOTS; k++)
         send_command(stq_pkg::CMD_FREE, 5'(k), 4'($urandom), $urandom, $urandom);
   endtask

   task automatic test_random_traffic(input int count, input int idle);
      logic [2:0]  cmd;
      logic [4:0]  idx;
      logic [3:0]  dest;
      logic [31:0] value;
      logic [31:0] tmo;
      int          r;
      idle_pct = idle;
      repeat (count) begin
         r     = int'($urandom_range(0, 99));
         idx   = 5'($urandom);
         dest  = 4'($urandom);
         value = $urandom;
         tmo   = $urandom;
         if (r < 15) begin
            cmd = stq_pkg::CMD_ALLOCATE;
         end else if (r < 33) begin
            cmd = stq_pkg::CMD_BIND;
            if ($urandom_range(0, 9) != 0) idx = pick_taken_slot(idx);
         end else if (r < 58) begin
            cmd = stq_pkg::CMD_ARM;
            if ($urandom_range(0, 9) != 0) idx = pick_taken_slot(idx);
            tmo = pick_timeout();
            // The bench binds a timer before it can expire; the queue itself does not enforce this.
            if (slot_taken[idx] && !slot_running[idx] && !slot_bound[idx])
               cmd = stq_pkg::CMD_BIND;
         end else if (r < 85) begin
            cmd = stq_pkg::CMD_TICK;
         end else if (r < 97) begin
            cmd = stq_pkg::CMD_FREE;
            if ($urandom_range(0, 9) != 0) idx = pick_taken_slot(idx);
         end else begin
            cmd = 3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
         end
         send_command(cmd, idx, dest, value, tmo);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_basic_commands();
      test_equal_deadlines();
      test_deadline_wrap();
      test_full_pool();
      test_random_traffic(130, 0);
      test_random_traffic(110, 65);
      wait_for_results();
      test_random_traffic(110, 14);
      wait_for_results();
      if (failures == 0) begin
         $display("PASS sorted_timer_queue");
      end else begin
         $display("FAIL sorted_timer_queue");
      end
      $finish;
   end

endmodule
`default_nettype wire
